// ===== sv/wav_pcm16_stream_parser_assert.svh =====
// Assertion macros shared by the WAV parser modules.
`ifndef WAV_PCM16_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM16_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define WAVP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WAVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WAVP_ASSERT(lbl, ante, cons, msg)
`define WAVP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/wavp_pkg.sv =====
// Types, codes and helpers for the WAV PCM16 stream parser.
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN   = 32'd16;
  localparam logic [15:0] AUDIO_PCM = 16'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER,
    PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOT_RIFF  = 4'd1,
    ST_NOT_WAVE  = 4'd2,
    ST_FMT_SMALL = 4'd3,
    ST_TRUNC     = 4'd4,
    ST_NO_FMT    = 4'd5,
    ST_NO_DATA   = 4'd6,
    ST_NOT_PCM   = 4'd7,
    ST_ODD_DATA  = 4'd8
  } status_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [3:0]         status;
    logic               last;
  } res_t;

  // up to two results per input byte; r1 only ever follows r0
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } res_pair_t;

  function automatic status_t verdict(input logic hf, input logic hd,
                                      input logic [15:0] af, input logic odd);
    status_t st;
    if (!hf)                   st = ST_NO_FMT;
    else if (!hd)              st = ST_NO_DATA;
    else if (af != AUDIO_PCM)  st = ST_NOT_PCM;
    else if (odd)              st = ST_ODD_DATA;
    else                       st = ST_OK;
    return st;
  endfunction

  function automatic res_t mk_status(input status_t st);
    res_t r;
    r.kind   = KIND_STATUS;
    r.sample = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_sample(input logic [15:0] s);
    res_t r;
    r.kind   = KIND_SAMPLE;
    r.sample = signed'(s);
    r.status = ST_OK;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/wavp_core.sv =====
// Byte-wise RIFF/WAVE chunk walker: state update and result generation.
`include "wav_pcm16_stream_parser_assert.svh"
module wavp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic [7:0]          in_byte,
  input  logic                in_eos,
  output wavp_pkg::res_pair_t res
);
  import wavp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] cr_r, cr_nxt;
  logic        chunk_odd_r, chunk_odd_nxt;
  logic        have_fmt_r, have_fmt_nxt;
  logic        have_data_r, have_data_nxt;
  logic        data_odd_r, data_odd_nxt;
  logic [15:0] af_r, af_nxt;
  logic [7:0]  low_r, low_nxt;

  logic [31:0] word;
  logic        field_done;
  logic        cr_last;
  logic [31:0] cr_dec;
  logic        at_boundary;

  // little-endian field assembly: new byte enters at the top
  assign word        = {in_byte, fs_r[31:8]};
  assign field_done  = (bif_r == 2'd3);
  assign cr_last     = (cr_r == 32'd1);
  assign cr_dec      = cr_r - 32'd1;
  assign at_boundary = (phase_r == PH_ID && bif_r == 2'd0) || phase_r == PH_SKIP ||
                       phase_r == PH_PAD;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    bif_nxt       = bif_r;
    fs_nxt        = fs_r;
    cr_nxt        = cr_r;
    chunk_odd_nxt = chunk_odd_r;
    have_fmt_nxt  = have_fmt_r;
    have_data_nxt = have_data_r;
    data_odd_nxt  = data_odd_r;
    af_nxt        = af_r;
    low_nxt       = low_r;
    if (in_acc) begin
      if (in_eos) begin
        phase_nxt     = PH_RIFF;
        bif_nxt       = 2'd0;
        fs_nxt        = '0;
        have_fmt_nxt  = 1'b0;
        have_data_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SZ_FMT, PH_SZ_DATA,
          PH_SZ_OTHER: begin
            fs_nxt  = word;
            bif_nxt = bif_r + 2'd1;
            if (field_done) begin
              bif_nxt = 2'd0;
              fs_nxt  = '0;
              case (phase_r)
                PH_RIFF:  phase_nxt = (word == TAG_RIFF) ? PH_RSIZE : PH_HALT;
                PH_RSIZE: phase_nxt = PH_WAVE;
                PH_WAVE:  phase_nxt = (word == TAG_WAVE) ? PH_ID : PH_HALT;
                PH_ID: begin
                  if (word == TAG_FMT)       phase_nxt = PH_SZ_FMT;
                  else if (word == TAG_DATA) phase_nxt = PH_SZ_DATA;
                  else                       phase_nxt = PH_SZ_OTHER;
                end
                PH_SZ_FMT: begin
                  if (word < FMT_MIN) begin
                    phase_nxt = PH_HALT;
                  end else begin
                    chunk_odd_nxt = word[0];
                    fs_nxt        = word - FMT_MIN;  // extra fmt bytes to skip
                    cr_nxt        = FMT_MIN;
                    phase_nxt     = PH_FMT;
                  end
                end
                PH_SZ_DATA: begin
                  chunk_odd_nxt = word[0];
                  cr_nxt        = word;
                  if (word == 32'd0) begin
                    have_data_nxt = 1'b1;
                    data_odd_nxt  = 1'b0;
                    phase_nxt     = have_fmt_r ? PH_HALT : PH_ID;
                  end else begin
                    phase_nxt = PH_DATA;
                  end
                end
                default: begin
                  chunk_odd_nxt = word[0];
                  cr_nxt        = word;
                  phase_nxt     = (word == 32'd0) ? PH_ID : PH_SKIP;
                end
              endcase
            end
          end
          PH_FMT: begin
            if (cr_r == FMT_MIN)              af_nxt = {8'h00, in_byte};
            else if (cr_r == FMT_MIN - 32'd1) af_nxt = {in_byte, af_r[7:0]};
            cr_nxt = cr_dec;
            if (cr_last) begin
              have_fmt_nxt = 1'b1;
              if (have_data_r) begin
                phase_nxt = PH_HALT;
              end else begin
                cr_nxt = fs_r;
                fs_nxt = '0;
                if (fs_r != 32'd0) begin
                  phase_nxt = PH_SKIP;
                end else begin
                  phase_nxt = chunk_odd_r ? PH_PAD : PH_ID;
                  bif_nxt   = 2'd0;
                end
              end
            end
          end
          PH_DATA: begin
            if (bif_r == 2'd0) begin
              low_nxt = in_byte;
              bif_nxt = 2'd1;
            end else begin
              bif_nxt = 2'd0;
            end
            cr_nxt = cr_dec;
            if (cr_last) begin
              have_data_nxt = 1'b1;
              data_odd_nxt  = chunk_odd_r;
              bif_nxt       = 2'd0;
              fs_nxt        = '0;
              if (have_fmt_r) phase_nxt = PH_HALT;
              else            phase_nxt = chunk_odd_r ? PH_PAD : PH_ID;
            end
          end
          PH_SKIP: begin
            cr_nxt = cr_dec;
            if (cr_last) begin
              phase_nxt = chunk_odd_r ? PH_PAD : PH_ID;
              fs_nxt    = '0;
              bif_nxt   = 2'd0;
            end
          end
          PH_PAD: begin
            phase_nxt = PH_ID;
            fs_nxt    = '0;
            bif_nxt   = 2'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // results caused by the accepted byte
  always_comb begin
    res = '0;
    if (in_acc) begin
      if (in_eos) begin
        if (phase_r != PH_HALT) begin
          res.v0 = 1'b1;
          res.r0 = mk_status(at_boundary ?
                             verdict(have_fmt_r, have_data_r, af_r, data_odd_r) :
                             ST_TRUNC);
        end
      end else begin
        case (phase_r)
          PH_RIFF: begin
            if (field_done && word != TAG_RIFF) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(ST_NOT_RIFF);
            end
          end
          PH_WAVE: begin
            if (field_done && word != TAG_WAVE) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(ST_NOT_WAVE);
            end
          end
          PH_SZ_FMT: begin
            if (field_done && word < FMT_MIN) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(ST_FMT_SMALL);
            end
          end
          PH_SZ_DATA: begin
            if (field_done && word == 32'd0 && have_fmt_r) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(verdict(1'b1, 1'b1, af_r, 1'b0));
            end
          end
          PH_FMT: begin
            if (cr_last && have_data_r) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(verdict(1'b1, 1'b1, af_r, data_odd_r));
            end
          end
          PH_DATA: begin
            if (bif_r != 2'd0) begin
              res.v0 = 1'b1;
              res.r0 = mk_sample({in_byte, low_r});
              if (cr_last && have_fmt_r) begin
                res.v1 = 1'b1;
                res.r1 = mk_status(verdict(1'b1, 1'b1, af_r, chunk_odd_r));
              end
            end else if (cr_last && have_fmt_r) begin
              res.v0 = 1'b1;
              res.r0 = mk_status(verdict(1'b1, 1'b1, af_r, chunk_odd_r));
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      bif_r       <= 2'd0;
      fs_r        <= '0;
      have_fmt_r  <= 1'b0;
      have_data_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
      fs_r        <= fs_nxt;
      have_fmt_r  <= have_fmt_nxt;
      have_data_r <= have_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r        <= '0;
      chunk_odd_r <= 1'b0;
      data_odd_r  <= 1'b0;
      af_r        <= '0;
      low_r       <= '0;
    end else begin
      cr_r        <= cr_nxt;
      chunk_odd_r <= chunk_odd_nxt;
      data_odd_r  <= data_odd_nxt;
      af_r        <= af_nxt;
      low_r       <= low_nxt;
    end
  end

  `WAVP_ASSERT(a_pair_order, res.v1, res.v0 && res.r0.kind == KIND_SAMPLE && res.r1.kind == KIND_STATUS, "second result must be a status after a sample")
  `WAVP_ASSERT_NEXT(a_status_halts, (res.v0 && res.r0.last) || res.v1, phase_r == PH_HALT || phase_r == PH_RIFF, "parser kept running after a final status")
  `WAVP_ASSERT(a_data_pairing, phase_r == PH_DATA, !bif_r[1], "byte pair counter out of range in data body")

endmodule

// ===== sv/wavp_outq.sv =====
// Four-entry result queue: takes up to two results per cycle, gives one per cycle when popped.
`include "wav_pcm16_stream_parser_assert.svh"
module wavp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  wavp_pkg::res_pair_t push,
  input  logic                pop,
  output wavp_pkg::res_t      head,
  output logic                nonempty,
  output logic                room
);
  import wavp_pkg::*;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        push_n;
  logic              pop_ok;

  assign push_n   = {1'b0, push.v0} + {1'b0, push.v1};
  assign nonempty = (count_r != '0);
  assign room     = (count_r <= QCNT_W'(QDEPTH - 2));
  assign pop_ok   = pop && nonempty;
  assign head     = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + QCNT_W'(push_n);
    if (pop_ok) count_nxt = count_nxt - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push.v0) q_r[wr_ptr_r] <= push.r0;
    if (push.v1) q_r[wr_ptr_r + QPTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (pop_ok) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r  <= count_nxt;
    end
  end

  `WAVP_ASSERT(a_no_overflow, push.v0, ({1'b0, count_r} + (QCNT_W + 1)'(push_n)) <= (QCNT_W + 1)'(QDEPTH), "result queue overflow")
  `WAVP_ASSERT_NEXT(a_pop_only, pop_ok && !push.v0, count_r == $past(count_r) - QCNT_W'(1), "queue count lost track on pop")
  `WAVP_ASSERT(a_ptr_gap, 1'b1, QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r), "queue pointers disagree with count")

endmodule

// ===== sv/wav_pcm16_stream_parser.sv =====
// WAV PCM16 stream parser top level: byte stream in, samples and status out.
//
//  channel  dir  tdata                          tuser         tlast
//  in_      in   [7:0] data_byte                -             end_of_stream
//  out_     out  [15:0] sample, [19:16] status  [0] kind      last
//
// One byte per cycle while in_tready is high: each accepted byte updates
// the chunk walker in that cycle and its results (at most two: the last
// sample and the final status) enter a four-entry queue; results leave one
// per cycle when popped. in_tready drops only while the queue holds more
// than two results. Reset clears the walker to expect the RIFF tag and
// empties the queue. end_of_stream rearms the walker for the next file.
module wav_pcm16_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] sample, [19:16] status, [23:20] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);
  import wavp_pkg::*;

  logic      in_acc;
  res_pair_t res;
  res_t      head;
  logic      room;

  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  wavp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .res     (res)
  );

  wavp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res),
    .pop      (out_tready),
    .head     (head),
    .nonempty (out_tvalid),
    .room     (room)
  );

  assign out_tdata = {4'b0000, head.status, head.sample};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ===== tb/wav_pcm16_stream_parser_test.sv =====
// Self-checking testbench for the WAV PCM16 stream parser.
`timescale 1ns / 1ps

module wav_pcm16_stream_parser_test;
  import wavp_pkg::*;

  localparam int HOLD_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_stream
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] sample, [19:16] status, [23:20] zero
  logic        out_tuser;  // [0] kind
  logic        out_tlast;

  logic idle_en = 1'b1;
  logic hold_req = 1'b0;
  int   err_cnt = 0;
  int   items_sent = 0;

  res_t       parsed_q[$];
  logic [7:0] wav_q[$];

  // shadow of the chunk walker
  phase_t      ph;
  logic [2:0]  nib;
  logic [31:0] shreg;
  logic [31:0] remain;
  logic        odd_sz;
  logic        seen_fmt;
  logic        seen_data;
  logic [15:0] fmt_code;
  logic [7:0]  lo_hold;
  logic        done;
  logic        data_was_odd;

  wav_pcm16_stream_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic walker_clear();
    ph           = PH_RIFF;
    nib          = '0;
    shreg        = '0;
    remain       = '0;
    odd_sz       = 1'b0;
    seen_fmt     = 1'b0;
    seen_data    = 1'b0;
    fmt_code     = '0;
    lo_hold      = '0;
    done         = 1'b0;
    data_was_odd = 1'b0;
  endtask

  function automatic status_t file_verdict();
    if (!seen_fmt)             return ST_NO_FMT;
    if (!seen_data)            return ST_NO_DATA;
    if (fmt_code != AUDIO_PCM) return ST_NOT_PCM;
    if (data_was_odd)          return ST_ODD_DATA;
    return ST_OK;
  endfunction

  task automatic push_status(input status_t st);
    res_t r;
    r.kind   = KIND_STATUS;
    r.sample = '0;
    r.status = st;
    r.last   = 1'b1;
    parsed_q.push_back(r);
  endtask

  task automatic halt(input status_t st);
    push_status(st);
    done = 1'b1;
    ph   = PH_HALT;
  endtask

  task automatic after_body();
    ph    = odd_sz ? PH_PAD : PH_ID;
    shreg = '0;
    nib   = '0;
  endtask

  task automatic data_end();
    seen_data    = 1'b1;
    data_was_odd = odd_sz;
    nib          = '0;
    if (seen_fmt) halt(file_verdict());
    else after_body();
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    logic [31:0] v;
    res_t        r;
    if (eos) begin
      // rearm; a file that already reported stays silent
      if (!done) begin
        if ((ph == PH_ID && nib == 0) || ph == PH_SKIP || ph == PH_PAD)
          push_status(file_verdict());
        else
          push_status(ST_TRUNC);
      end
      walker_clear();
      return;
    end
    if (done || ph == PH_HALT) return;

    if (ph <= PH_SZ_OTHER) begin
      shreg = {b, shreg[31:8]};
      nib   = nib + 3'd1;
      if (nib < 3'd4) return;
      nib   = '0;
      v     = shreg;
      shreg = '0;
      case (ph)
        PH_RIFF: begin
          if (v != TAG_RIFF) halt(ST_NOT_RIFF);
          else ph = PH_RSIZE;
        end
        PH_RSIZE: ph = PH_WAVE;
        PH_WAVE: begin
          if (v != TAG_WAVE) halt(ST_NOT_WAVE);
          else ph = PH_ID;
        end
        PH_ID: begin
          ph = (v == TAG_FMT) ? PH_SZ_FMT :
               (v == TAG_DATA) ? PH_SZ_DATA : PH_SZ_OTHER;
        end
        PH_SZ_FMT: begin
          if (v < FMT_MIN) halt(ST_FMT_SMALL);
          else begin
            odd_sz = v[0];
            shreg  = v - FMT_MIN;  // extra fmt bytes to skip
            remain = FMT_MIN;
            ph     = PH_FMT;
          end
        end
        PH_SZ_DATA: begin
          odd_sz = v[0];
          remain = v;
          if (v == 0) data_end();
          else ph = PH_DATA;
        end
        default: begin
          odd_sz = v[0];
          remain = v;
          if (v == 0) after_body();
          else ph = PH_SKIP;
        end
      endcase
      return;
    end

    case (ph)
      PH_FMT: begin
        if (remain == FMT_MIN) fmt_code = {8'h00, b};
        else if (remain == FMT_MIN - 1) fmt_code[15:8] = b;
        remain = remain - 1;
        if (remain == 0) begin
          seen_fmt = 1'b1;
          if (seen_data) halt(file_verdict());
          else begin
            remain = shreg;
            shreg  = '0;
            if (remain != 0) ph = PH_SKIP;
            else after_body();
          end
        end
      end
      PH_DATA: begin
        if (nib == 0) begin
          lo_hold = b;
          nib     = 3'd1;
        end else begin
          r.kind   = KIND_SAMPLE;
          r.sample = {b, lo_hold};
          r.status = ST_OK;
          r.last   = 1'b0;
          parsed_q.push_back(r);
          nib = '0;
        end
        remain = remain - 1;
        if (remain == 0) data_end();
      end
      PH_SKIP: begin
        remain = remain - 1;
        if (remain == 0) after_body();
      end
      PH_PAD: begin
        ph    = PH_ID;
        shreg = '0;
        nib   = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- driving

  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, eos);
    items_sent++;
  endtask

  // sends the assembled bytes, then the end-of-stream transaction
  task automatic stream_file();
    foreach (wav_q[i]) push_byte(wav_q[i], 1'b0);
    wav_q.delete();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) wav_q.push_back(v[8*i +: 8]);
  endtask

  task automatic add_rand(input int n);
    for (int i = 0; i < n; i++) wav_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_pad(input logic [31:0] sz);
    if (sz[0]) add_rand(1);
  endtask

  task automatic add_header();
    add_le(TAG_RIFF, 4);
    add_le($urandom(), 4);
    add_le(TAG_WAVE, 4);
  endtask

  task automatic add_fmt(input int sz, input logic [15:0] code);
    add_le(TAG_FMT, 4);
    add_le(sz, 4);
    if (sz >= 16) begin
      add_le(32'(code), 2);
      add_rand(sz - 2);
      add_pad(sz);
    end
  endtask

  task automatic add_data(input int sz);
    add_le(TAG_DATA, 4);
    add_le(sz, 4);
    add_rand(sz);
    add_pad(sz);
  endtask

  task automatic add_other(input int sz);
    add_le($urandom(), 4);
    add_le(sz, 4);
    add_rand(sz);
    add_pad(sz);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic cmp_field(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = parsed_q.pop_front();
        cmp_field("kind", 16'(want.kind), 16'(out_tuser));
        cmp_field("sample", want.sample, out_tdata[15:0]);
        cmp_field("status", 16'(want.status), 16'(out_tdata[19:16]));
        cmp_field("last", 16'(want.last), 16'(out_tlast));
        cmp_field("tdata pad", '0, 16'(out_tdata[23:20]));
      end
    end
  end

  initial begin : ready_gen
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req   <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_valid_pcm();
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_le(TAG_DATA, 4);
    add_le(10, 4);
    add_le(32'h0000_8000, 2);
    add_le(32'h0000_7FFF, 2);
    add_le(32'h0000_0000, 2);
    add_le(32'h0000_FFFF, 2);
    add_le(32'h0000_0001, 2);
    add_rand(3);  // ignored once complete
    stream_file();
    stream_file();  // end-of-stream right after reset state: truncated tag
  endtask

  task automatic test_header_errors();
    add_le(TAG_RIFF ^ 32'h0100_0000, 4);
    add_rand(2);
    stream_file();
    add_le(TAG_RIFF, 4);
    add_rand(4);
    add_le(~TAG_WAVE, 4);
    stream_file();
    add_header();
    add_fmt(15, AUDIO_PCM);
    add_rand(3);
    stream_file();
    add_header();
    add_fmt(0, AUDIO_PCM);
    stream_file();
  endtask

  task automatic test_truncation();
    add_rand(2);
    stream_file();
    add_le(TAG_RIFF, 4);
    add_rand(2);
    stream_file();
    add_header();
    add_rand(2);  // half a chunk id
    stream_file();
    add_header();
    add_le(TAG_FMT, 4);
    add_le(16, 4);
    add_rand(5);
    stream_file();
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_le(TAG_DATA, 4);
    add_le(6, 4);
    add_rand(3);
    stream_file();
  endtask

  task automatic test_missing_chunks();
    add_header();
    stream_file();
    add_header();
    add_fmt(16, AUDIO_PCM);
    stream_file();
    add_header();
    add_data(4);  // samples before any fmt
    stream_file();
    // huge unknown chunk, stream ends inside the skip
    add_header();
    add_le($urandom(), 4);
    add_le(32'hFFFF_FFFF, 4);
    add_rand(5);
    stream_file();
    // odd unknown chunk, stream ends before its pad byte
    add_header();
    add_le($urandom(), 4);
    add_le(3, 4);
    add_rand(3);
    stream_file();
  endtask

  task automatic test_format_checks();
    add_header();
    add_fmt(16, 16'd3);
    add_data(4);
    stream_file();
    add_header();
    add_fmt(16, 16'h0101);
    add_data(2);
    stream_file();
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_data(3);
    stream_file();
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_data(0);
    stream_file();
  endtask

  task automatic test_chunk_walk();
    // pad after odd chunk, data first, fmt with odd extra bytes
    add_header();
    add_other(5);
    add_data(4);
    add_fmt(19, AUDIO_PCM);
    stream_file();
    // later fmt replaces the format, empty unknown chunk
    add_header();
    add_fmt(18, 16'd3);
    add_other(0);
    add_fmt(16, AUDIO_PCM);
    add_data(5);
    stream_file();
    // later data chunk replaces the odd flag
    add_header();
    add_data(3);
    add_data(2);
    add_fmt(16, AUDIO_PCM);
    stream_file();
    // huge fmt, stream ends while skipping its extra bytes
    add_header();
    add_le(TAG_FMT, 4);
    add_le(32'hFFFF_FFFF, 4);
    add_le(32'(AUDIO_PCM), 2);
    add_rand(20);
    stream_file();
  endtask

  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req <= 1'b1;
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_data(40);
    stream_file();
    idle_en = 1'b1;
  endtask

  task automatic random_file();
    int sel;
    int sz;
    int cut;
    sel = $urandom_range(0, 15);
    add_le((sel == 0) ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF, 4);
    add_le($urandom(), 4);
    add_le((sel == 1) ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE, 4);
    repeat ($urandom_range(1, 4)) begin
      sel = $urandom_range(0, 9);
      if (sel <= 2) begin
        if ($urandom_range(0, 7) == 0) sz = $urandom_range(0, 15);
        else if ($urandom_range(0, 3) == 0) sz = 16 + $urandom_range(1, 5);
        else sz = 16;
        add_fmt(sz, ($urandom_range(0, 5) == 0) ? 16'($urandom()) : AUDIO_PCM);
      end else if (sel <= 6) begin
        add_data($urandom_range(0, 12));
      end else begin
        add_other($urandom_range(0, 7));
      end
    end
    if ($urandom_range(0, 3) == 0) add_rand($urandom_range(1, 3));
    if ($urandom_range(0, 5) == 0 && wav_q.size() > 0) begin
      cut = $urandom_range(0, wav_q.size() - 1);
      while (wav_q.size() > cut) void'(wav_q.pop_back());
    end
    stream_file();
  endtask

  // random files until the run is near its total transaction count
  task automatic test_random_files();
    do random_file(); while (items_sent < 900);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (2) random_file();
    add_header();
    add_fmt(16, AUDIO_PCM);
    add_data(8);
    stream_file();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    walker_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_pcm();
    test_header_errors();
    test_truncation();
    test_missing_chunks();
    test_format_checks();
    test_chunk_walk();
    test_backpressure();
    test_random_files();
    test_no_idle();

    in_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && parsed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
